// ===== hw/rtl/sha1_pkg.sv =====
// ----------------------------------------------------------------------------
// SHA-1 package
// Types and constants shared by the SHA-1 byte stream hasher.
// ----------------------------------------------------------------------------
`default_nettype none

package sha1_pkg;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       byte_present;
      logic       start_message;
      logic       end_message;
   } req_type;

   typedef struct packed {
      logic [31:0] digest_word;
      logic [2:0]  word_index;
      logic        last_word;
   } rsp_type;

   localparam logic [31:0] K0 = 32'h5A827999;
   localparam logic [31:0] K1 = 32'h6ED9EBA1;
   localparam logic [31:0] K2 = 32'h8F1BBCDC;
   localparam logic [31:0] K3 = 32'hCA62C1D6;

   localparam logic [31:0] H0_INIT = 32'h67452301;
   localparam logic [31:0] H1_INIT = 32'hEFCDAB89;
   localparam logic [31:0] H2_INIT = 32'h98BADCFE;
   localparam logic [31:0] H3_INIT = 32'h10325476;
   localparam logic [31:0] H4_INIT = 32'hC3D2E1F0;

   localparam logic [5:0] PAD_MARK   = 6'd56;
   localparam logic [5:0] INDEX_LAST = 6'd63;
   localparam logic [7:0] PAD_BYTE   = 8'h80;

   // round engine control
   typedef struct packed {
      logic       start;   // load working vars from chaining words
      logic       init;    // reload chaining words with initial values
   } rnd_ctl_type;

endpackage

`default_nettype wire

// ===== hw/rtl/sha1_byte_stream_hasher.sv =====
// ----------------------------------------------------------------------------
// SHA-1 byte stream hasher
// One byte per request into a 64-byte block memory; 80-round compression.
// ----------------------------------------------------------------------------
// A request carrying a byte passes ST_BYTE and ST_WAIT; one that fills a block also
// passes ST_LOAD and ST_FEED, where the single round engine does one round per cycle
// and the block memory delivers one word every cycle. A request with neither a byte
// nor an end returns to ST_IDLE. An end request pads byte by byte through ST_PAD and
// ST_WAIT, compressing each block it fills, then returns five digest words, one per
// cycle when not stalled. req_stall is high throughout.
`default_nettype none

module sha1_byte_stream_hasher
   import sha1_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data
);

   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_BYTE  = 7'b0000010,
      ST_FEED  = 7'b0000100,
      ST_WAIT  = 7'b0001000,
      ST_PAD   = 7'b0010000,
      ST_OUT   = 7'b0100000,
      ST_LOAD  = 7'b1000000
   } state_type;

   state_type   state_ff, state_in;
   logic [63:0] cnt_ff, cnt_in;
   logic [63:0] bits_ff, bits_in;
   logic        endm_ff, endm_in;
   logic        padding_ff, padding_in;
   logic        len_ff, len_in;
   logic [7:0]  byte_ff, byte_in;
   logic [2:0]  oidx_ff, oidx_in;
   logic [3:0]  rd_ff, rd_in;
   logic [31:0] mem [16];
   logic [31:0] rdata_ff;
   logic        wr_en;
   logic [7:0]  pad_b;
   rnd_ctl_type ctl;
   logic        busy;
   logic [159:0] chain;

   sha1_round u_round (
      .clock    (clock),
      .reset    (reset),
      .ctl      (ctl),
      .msg_word (rdata_ff),
      .busy     (busy),
      .chain    (chain)
   );

   always_comb begin
      pad_b = 8'h00;
      if (!padding_ff) pad_b = PAD_BYTE;
      else if (len_ff || cnt_ff[5:0] == PAD_MARK) pad_b = bits_ff[63 - 8*cnt_ff[2:0] -: 8];
   end

   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      bits_in = bits_ff;
      endm_in = endm_ff;
      padding_in = padding_ff;
      len_in = len_ff;
      byte_in = byte_ff;
      oidx_in = oidx_ff;
      rd_in = rd_ff;
      wr_en = 1'b0;
      ctl = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               endm_in = req_data.end_message;
               byte_in = req_data.data_byte;
               padding_in = 1'b0;
               len_in = 1'b0;
               if (req_data.start_message) begin
                  ctl.init = 1'b1;
                  cnt_in = '0;
               end
               state_in = req_data.byte_present ? ST_BYTE : ST_WAIT;
               if (!req_data.byte_present && req_data.end_message) begin
                  bits_in = (req_data.start_message ? 64'd0 : cnt_ff) << 3;
                  state_in = ST_PAD;
               end else if (!req_data.byte_present) begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_BYTE, ST_PAD: begin
            if (state_ff == ST_PAD) byte_in = pad_b;
            wr_en = 1'b1;
            cnt_in = cnt_ff + 64'd1;
            if (state_ff == ST_BYTE && endm_ff) bits_in = (cnt_ff + 64'd1) << 3;
            if (state_ff == ST_PAD) padding_in = 1'b1;
            if (state_ff == ST_PAD && padding_ff && cnt_ff[5:0] == PAD_MARK) len_in = 1'b1;
            if (cnt_ff[5:0] == INDEX_LAST) begin
               state_in = ST_LOAD;
               rd_in = '0;
            end else begin
               state_in = ST_WAIT;
            end
         end
         ST_LOAD: begin
            rd_in = rd_ff + 4'd1;
            ctl.start = 1'b1;
            state_in = ST_FEED;
         end
         ST_FEED: begin
            rd_in = rd_ff + 4'd1;
            if (!busy) state_in = ST_WAIT;
         end
         ST_WAIT: begin
            if (!endm_ff) state_in = ST_IDLE;
            else if (len_ff && cnt_ff[5:0] == 6'd0) begin
               state_in = ST_OUT;
               oidx_in = '0;
            end else state_in = ST_PAD;
         end
         ST_OUT: begin
            if (!rsp_stall) begin
               oidx_in = oidx_ff + 3'd1;
               if (oidx_ff == 3'd4) begin
                  state_in = ST_IDLE;
                  ctl.init = 1'b1;
                  cnt_in = '0;
                  endm_in = 1'b0;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // byte lane write into word memory
   always_ff @(posedge clock) begin
      if (wr_en) mem[cnt_ff[5:2]][8*(3 - cnt_ff[1:0]) +: 8] <=
         (state_ff == ST_PAD) ? pad_b : byte_ff;
      rdata_ff <= (state_ff == ST_BYTE || state_ff == ST_PAD) ? mem[4'd0] : mem[rd_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff <= '0;
         endm_ff <= 1'b0;
         padding_ff <= 1'b0;
         len_ff <= 1'b0;
         oidx_ff <= '0;
         rd_ff <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         endm_ff <= endm_in;
         padding_ff <= padding_in;
         len_ff <= len_in;
         oidx_ff <= oidx_in;
         rd_ff <= rd_in;
      end
      bits_ff <= bits_in;
      byte_ff <= byte_in;
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_OUT);
   assign rsp_data.digest_word = chain[159 - 32*oidx_ff -: 32];
   assign rsp_data.word_index  = oidx_ff;
   assign rsp_data.last_word   = (oidx_ff == 3'd4);

endmodule

`default_nettype wire

// ===== hw/rtl/sha1_round.sv =====
// ----------------------------------------------------------------------------
// SHA-1 round engine
// Shared round unit: one round per cycle for 80 rounds, rolling schedule,
// chaining word update at the end of each block.
// ----------------------------------------------------------------------------
`default_nettype none

module sha1_round
   import sha1_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire rnd_ctl_type ctl,
   input  wire logic [31:0] msg_word,
   output logic             busy,
   output logic [159:0]     chain
);

   logic [31:0] h_ff [5];
   logic [31:0] h_in [5];
   logic [31:0] a_ff, b_ff, c_ff, d_ff, e_ff;
   logic [31:0] w_ff [16];
   logic [6:0]  t_ff, t_in;
   logic        busy_ff, busy_in;
   logic        fin_ff, fin_in;

   logic [31:0] w_new, f, k, tmp, x;

   always_comb begin
      x = w_ff[13] ^ w_ff[8] ^ w_ff[2] ^ w_ff[0];
      w_new = (t_ff < 7'd16) ? msg_word : {x[30:0], x[31]};
      if (t_ff < 7'd20) begin
         f = d_ff ^ (b_ff & (c_ff ^ d_ff));
         k = K0;
      end else if (t_ff < 7'd40) begin
         f = b_ff ^ c_ff ^ d_ff;
         k = K1;
      end else if (t_ff < 7'd60) begin
         f = (b_ff & c_ff) | (d_ff & (b_ff | c_ff));
         k = K2;
      end else begin
         f = b_ff ^ c_ff ^ d_ff;
         k = K3;
      end
      tmp = {a_ff[26:0], a_ff[31:27]} + e_ff + w_new + f + k;
   end

   always_comb begin
      busy_in = busy_ff;
      t_in = t_ff;
      fin_in = 1'b0;
      for (int i = 0; i < 5; i++) h_in[i] = h_ff[i];
      if (ctl.start) begin
         busy_in = 1'b1;
         t_in = '0;
      end else if (busy_ff) begin
         t_in = t_ff + 7'd1;
         if (t_ff == 7'd79) begin
            busy_in = 1'b0;
            fin_in = 1'b1;
         end
      end
      if (fin_ff) begin
         h_in[0] = h_ff[0] + a_ff;
         h_in[1] = h_ff[1] + b_ff;
         h_in[2] = h_ff[2] + c_ff;
         h_in[3] = h_ff[3] + d_ff;
         h_in[4] = h_ff[4] + e_ff;
      end
      if (ctl.init) begin
         h_in[0] = H0_INIT;
         h_in[1] = H1_INIT;
         h_in[2] = H2_INIT;
         h_in[3] = H3_INIT;
         h_in[4] = H4_INIT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         fin_ff  <= 1'b0;
         t_ff    <= '0;
         h_ff[0] <= H0_INIT;
         h_ff[1] <= H1_INIT;
         h_ff[2] <= H2_INIT;
         h_ff[3] <= H3_INIT;
         h_ff[4] <= H4_INIT;
      end else begin
         busy_ff <= busy_in;
         fin_ff  <= fin_in;
         t_ff    <= t_in;
         for (int i = 0; i < 5; i++) h_ff[i] <= h_in[i];
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.start) begin
         a_ff <= h_ff[0];
         b_ff <= h_ff[1];
         c_ff <= h_ff[2];
         d_ff <= h_ff[3];
         e_ff <= h_ff[4];
      end else if (busy_ff) begin
         e_ff <= d_ff;
         d_ff <= c_ff;
         c_ff <= {b_ff[1:0], b_ff[31:2]};
         b_ff <= a_ff;
         a_ff <= tmp;
         for (int i = 0; i < 15; i++) w_ff[i] <= w_ff[i+1];
         w_ff[15] <= w_new;
      end
   end

   assign busy  = busy_ff | fin_ff | ctl.start;
   assign chain = {h_ff[0], h_ff[1], h_ff[2], h_ff[3], h_ff[4]};

endmodule

`default_nettype wire

// ===== dv/sha1_byte_stream_hasher_tb.sv =====
// ----------------------------------------------------------------------------
// SHA-1 byte stream hasher testbench
// Drives byte requests and checks each digest word against an in-bench SHA-1
// model or known digest; a directed table (dropped, restarted messages) is
// followed by random messages. The sender idles in bursts, the receiver
// stalls on its own pattern, and one long receiver hold backs up the block.
// ----------------------------------------------------------------------------
`default_nettype none

module sha1_byte_stream_hasher_tb;
   import sha1_pkg::*;

   localparam int RANDOM_REQUESTS = 470;
   localparam int CYCLE_LIMIT     = 600000;
   localparam int LONG_HOLD       = 600;
   localparam int DRAIN_CYCLES    = 300;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   sha1_byte_stream_hasher u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #2 clock = ~clock;

   // ---------------- SHA-1 model ----------------
   logic [31:0] hash_words[5];
   logic [7:0]  block_bytes[64];
   logic [63:0] msg_bytes;
   logic [31:0] sched_words[16];
   rsp_type     digest_q[$];

   int error_count  = 0;
   int words_seen   = 0;
   int sent_count   = 0;
   int msg_count    = 0;
   int cycle_count  = 0;
   int burst_left   = 4;
   bit hold_armed   = 0;

   function automatic logic [31:0] rol(logic [31:0] x, int n);
      return (x << n) | (x >> (32 - n));
   endfunction

   task automatic restart_hash();
      hash_words[0] = H0_INIT;
      hash_words[1] = H1_INIT;
      hash_words[2] = H2_INIT;
      hash_words[3] = H3_INIT;
      hash_words[4] = H4_INIT;
      msg_bytes = '0;
   endtask

   task automatic compress_block();
      logic [31:0] a, b, c, d, e, w, f, k, tmp;
      a = hash_words[0]; b = hash_words[1]; c = hash_words[2];
      d = hash_words[3]; e = hash_words[4];
      for (int t = 0; t < 80; t++) begin
         if (t < 16) begin
            w = {block_bytes[4*t], block_bytes[4*t+1], block_bytes[4*t+2],
                 block_bytes[4*t+3]};
         end else begin
            w = rol(sched_words[(t+13)%16] ^ sched_words[(t+8)%16] ^
                    sched_words[(t+2)%16] ^ sched_words[t%16], 1);
         end
         sched_words[t%16] = w;
         if (t < 20) begin
            f = d ^ (b & (c ^ d)); k = K0;
         end else if (t < 40) begin
            f = b ^ c ^ d; k = K1;
         end else if (t < 60) begin
            f = (b & c) | (d & (b | c)); k = K2;
         end else begin
            f = b ^ c ^ d; k = K3;
         end
         tmp = rol(a, 5) + e + w + f + k;
         e = d; d = c; c = rol(b, 30); b = a; a = tmp;
      end
      hash_words[0] += a; hash_words[1] += b; hash_words[2] += c;
      hash_words[3] += d; hash_words[4] += e;
   endtask

   task automatic absorb_byte(logic [7:0] v);
      logic [5:0] idx;
      idx = msg_bytes[5:0];
      block_bytes[idx] = v;
      msg_bytes += 64'd1;
      if (idx == INDEX_LAST) compress_block();
   endtask

   // Updates the model; queues model digest unless a typed digest is given.
   task automatic predict_digest(req_type r, bit typed, logic [4:0][31:0] known);
      logic [63:0] bit_len;
      rsp_type w;
      if (r.start_message) restart_hash();
      if (r.byte_present) absorb_byte(r.data_byte);
      if (r.end_message) begin
         bit_len = msg_bytes << 3;
         absorb_byte(PAD_BYTE);
         while (msg_bytes[5:0] != PAD_MARK) absorb_byte(8'h00);
         for (int i = 0; i < 8; i++) absorb_byte(bit_len[(7-i)*8 +: 8]);
         for (int i = 0; i < 5; i++) begin
            w.digest_word = typed ? known[4-i] : hash_words[i];
            w.word_index  = 3'(i);
            w.last_word   = (i == 4);
            digest_q.push_back(w);
         end
         msg_count++;
         restart_hash();
      end
   endtask

   // ---------------- sender ----------------
   task automatic send_request(req_type r, bit typed, logic [4:0][31:0] known);
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (req_stall);
      predict_digest(r, typed, known);
      sent_count++;
      burst_left--;
      if (burst_left <= 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(1, 12);
      end
   endtask

   function automatic req_type mk(logic [7:0] d, bit p, bit s, bit e);
      mk.data_byte = d; mk.byte_present = p; mk.start_message = s;
      mk.end_message = e;
   endfunction

   typedef struct {
      req_type          r;
      bit               typed;
      logic [4:0][31:0] known;
   } table_row_type;

   localparam logic [4:0][31:0] EMPTY_DIGEST =
      {32'hDA39A3EE, 32'h5E6B4B0D, 32'h3255BFEF, 32'h95601890, 32'hAFD80709};
   localparam logic [4:0][31:0] ABC_DIGEST =
      {32'hA9993E36, 32'h4706816A, 32'hBA3E2571, 32'h7850C26C, 32'h9CD0D89D};

   table_row_type directed[$];

   initial begin
      req_type r;
      int n;
      bit broken;
      restart_hash();
      directed = '{
         '{mk(8'h00, 0, 1, 1), 1, EMPTY_DIGEST},  // empty message
         '{mk(8'h61, 1, 1, 0), 0, '0},
         '{mk(8'h62, 1, 0, 0), 0, '0},
         '{mk(8'h63, 1, 0, 1), 1, ABC_DIGEST},
         '{mk(8'hFF, 1, 1, 0), 0, '0},            // dropped by restart
         '{mk(8'h00, 1, 0, 0), 0, '0},
         '{mk(8'hFF, 1, 0, 0), 0, '0},
         '{mk(8'h41, 1, 1, 0), 0, '0},
         '{mk(8'h5A, 0, 0, 0), 0, '0},            // no byte, ignored
         '{mk(8'hA5, 0, 0, 1), 0, '0},            // end without byte
         '{mk(8'hFF, 1, 0, 0), 0, '0},            // fresh after end, no start
         '{mk(8'h00, 1, 0, 1), 0, '0},
         '{mk(8'h00, 0, 0, 1), 1, EMPTY_DIGEST},  // bare end is empty message
         '{mk(8'h00, 1, 1, 1), 0, '0},
         '{mk(8'hFF, 1, 1, 1), 0, '0}
      };
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      foreach (directed[i]) send_request(directed[i].r, directed[i].typed, directed[i].known);

      hold_armed = 1;
      n = 0;
      while (n < RANDOM_REQUESTS) begin
         int len;
         len = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 200)
                                           : $urandom_range(0, 70);
         broken = ($urandom_range(0, 11) == 0);
         for (int j = 0; j <= len; j++) begin
            r.data_byte     = 8'($urandom);
            r.byte_present  = ($urandom_range(0, 15) != 0);
            r.start_message = (j == 0) && ($urandom_range(0, 3) != 0);
            r.end_message   = (j == len) && !broken;
            if (r.byte_present || r.start_message || r.end_message) n++;
            send_request(r, 0, '0);
         end
      end
      req_valid <= 1'b0;

      while (digest_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Sent %0d requests forming %0d complete messages; checked %0d digest words.",
               sent_count, msg_count, words_seen);
      $display("Covered empty, restarted and multi-block messages under sender and receiver stalls.");
      if (error_count == 0 && digest_q.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   // ---------------- receiver stall pattern ----------------
   int  hold_left = 0;
   bit  hold_done = 0;
   int  stall_mode = 0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_armed && !hold_done) begin
         hold_done = 1;
         hold_left = LONG_HOLD;
         rsp_stall <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         if (cycle_count % 97 == 0) stall_mode = $urandom_range(0, 3);
         case (stall_mode)
            0: begin
               rsp_stall <= 1'b0;
            end
            1: begin
               rsp_stall <= ($urandom_range(0, 3) == 0);
            end
            2: begin
               rsp_stall <= (cycle_count % 3 != 0);
            end
            default: begin
               rsp_stall <= ($urandom_range(0, 1) == 0);
            end
         endcase
      end
   end

   // ---------------- digest checker ----------------
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         words_seen++;
         if (digest_q.size() == 0) begin
            $error("unexpected digest word %h", rsp_data.digest_word);
            error_count++;
         end else begin
            want = digest_q.pop_front();
            if (rsp_data.digest_word !== want.digest_word) begin
               $error("digest_word expected %h actual %h",
                      want.digest_word, rsp_data.digest_word);
               error_count++;
            end
            if (rsp_data.word_index !== want.word_index) begin
               $error("word_index expected %0d actual %0d",
                      want.word_index, rsp_data.word_index);
               error_count++;
            end
            if (rsp_data.last_word !== want.last_word) begin
               $error("last_word expected %0d actual %0d",
                      want.last_word, rsp_data.last_word);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycle_count);
         $display("CHECKS FAILED");
         $finish;
      end
   end

endmodule

`default_nettype wire

// ===== sha1_byte_stream_hasher.f =====
hw/rtl/sha1_pkg.sv
hw/rtl/sha1_round.sv
hw/rtl/sha1_byte_stream_hasher.sv
dv/sha1_byte_stream_hasher_tb.sv
